>>> rtl/rfidwge_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfidwge_pkg
// Shared types, codes and reset values of the tag write gap encoder.
// ----------------------------------------------------------------------------
package rfidwge_pkg;

  // field widths
  localparam int unsigned DataW   = 32;
  localparam int unsigned TickW   = 10;
  localparam int unsigned BlockW  = 3;
  localparam int unsigned FuncW   = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned SDataW  = 40;
  localparam int unsigned MDataW  = 8;

  // command selector codes on the input tuser
  localparam logic [FuncW-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FuncW-1:0] FUNC_WRITE = 2'd1;
  localparam logic [FuncW-1:0] FUNC_RESET = 2'd2;

  // register indexes of the configuration channel
  localparam logic [CfgIdxW-1:0] CFG_PASSWORD  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_WAIT      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_START_GAP = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_WRITE_GAP = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ZERO      = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_ONE       = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_PROGRAM   = 3'd6;

  // register reset values
  localparam logic [DataW-1:0] RST_PASSWORD  = 32'd0;
  localparam logic [TickW-1:0] RST_WAIT      = 10'd400;
  localparam logic [TickW-1:0] RST_START_GAP = 10'd30;
  localparam logic [TickW-1:0] RST_WRITE_GAP = 10'd18;
  localparam logic [TickW-1:0] RST_ZERO      = 10'd24;
  localparam logic [TickW-1:0] RST_ONE       = 10'd56;
  localparam logic [TickW-1:0] RST_PROGRAM   = 10'd700;

  // command class decided by the front end
  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_WRITE,
    KIND_RESET,
    KIND_NOP
  } kind_e;

  // queued command
  typedef struct packed {
    kind_e             kind;
    logic              page;
    logic [BlockW-1:0] block;
    logic              lock_flag;
    logic [DataW-1:0]  data;
    logic              pass_mode;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic carrier_on;
    logic busy_res;
    logic done_res;
    logic rejected;
  } res_t;

  // timing and password registers
  typedef struct packed {
    logic [DataW-1:0] password;
    logic [TickW-1:0] wait_ticks;
    logic [TickW-1:0] start_gap_ticks;
    logic [TickW-1:0] write_gap_ticks;
    logic [TickW-1:0] zero_ticks;
    logic [TickW-1:0] one_ticks;
    logic [TickW-1:0] program_ticks;
  } cfg_t;

endpackage

>>> rtl/rfid_tag_write_gap_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfid_tag_write_gap_encoder
// Carrier on/off envelope generator for block writes to a low-frequency tag.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   contents
//  s_axis    in         s_axis_tvalid/s_axis_tready  command or carrier tick
//  m_axis    out        m_axis_tvalid/m_axis_tready  one result per command
//  cfg       in         cfg_valid_i/cfg_ready_o      register index and value
//
//  One command per clock cycle sustained while m_axis_tready stays high; a result
//  passes through the input queue and then the result queue before transfer.
//  The sequencer handles each command from the input queue head; ticks are counted
//  by its 10-bit countdown. Reset clears the queues and returns the sequencer
//  to idle with default timing. Input and output queues hold two entries
//  each, so a short stall on either side does not block the other.
// ----------------------------------------------------------------------------
module rfid_tag_write_gap_encoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // page[0], block[3:1], lock_flag[4], data[36:5], pass_mode[37]
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [rfidwge_pkg::SDataW-1:0]      s_axis_tdata,
  // func[1:0]
  input  logic [rfidwge_pkg::FuncW-1:0]       s_axis_tuser,
  // carrier_on[0], busy_res[1], done_res[2], rejected[3]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [rfidwge_pkg::MDataW-1:0]      m_axis_tdata,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rfidwge_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [rfidwge_pkg::DataW-1:0]       cfg_data_i
);
  import rfidwge_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;
  res_t res;
  logic res_valid;
  logic res_ready;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.password        <= RST_PASSWORD;
      cfg_q.wait_ticks      <= RST_WAIT;
      cfg_q.start_gap_ticks <= RST_START_GAP;
      cfg_q.write_gap_ticks <= RST_WRITE_GAP;
      cfg_q.zero_ticks      <= RST_ZERO;
      cfg_q.one_ticks       <= RST_ONE;
      cfg_q.program_ticks   <= RST_PROGRAM;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PASSWORD:  cfg_q.password        <= cfg_data_i;
        CFG_WAIT:      cfg_q.wait_ticks      <= cfg_data_i[TickW-1:0];
        CFG_START_GAP: cfg_q.start_gap_ticks <= cfg_data_i[TickW-1:0];
        CFG_WRITE_GAP: cfg_q.write_gap_ticks <= cfg_data_i[TickW-1:0];
        CFG_ZERO:      cfg_q.zero_ticks      <= cfg_data_i[TickW-1:0];
        CFG_ONE:       cfg_q.one_ticks       <= cfg_data_i[TickW-1:0];
        CFG_PROGRAM:   cfg_q.program_ticks   <= cfg_data_i[TickW-1:0];
        default: ;
      endcase
    end
  end

  // command intake
  rfidwge_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  // envelope sequencer
  rfidwge_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // result queue
  rfidwge_outbuf u_outbuf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_valid_i   (res_valid),
    .res_i         (res),
    .res_ready_o   (res_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

>>> rtl/rfidwge_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfidwge_front
// Input side: unpacks and classifies commands into a two-entry queue.
// ----------------------------------------------------------------------------
module rfidwge_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [rfidwge_pkg::SDataW-1:0]      s_axis_tdata,
  input  logic [rfidwge_pkg::FuncW-1:0]       s_axis_tuser,
  output logic                                cmd_valid_o,
  output rfidwge_pkg::cmd_t                   cmd_o,
  input  logic                                cmd_pop_i
);
  import rfidwge_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  cmd_t       cmd_in;
  logic       push;
  logic       pop;

  // unpack tdata and classify the selector
  always_comb begin
    cmd_in.page      = s_axis_tdata[0];
    cmd_in.block     = s_axis_tdata[3:1];
    cmd_in.lock_flag = s_axis_tdata[4];
    cmd_in.data      = s_axis_tdata[36:5];
    cmd_in.pass_mode = s_axis_tdata[37];
    unique case (s_axis_tuser)
      FUNC_TICK:  cmd_in.kind = KIND_TICK;
      FUNC_WRITE: cmd_in.kind = KIND_WRITE;
      FUNC_RESET: cmd_in.kind = KIND_RESET;
      default:    cmd_in.kind = KIND_NOP;
    endcase
  end

  // queue control
  assign s_axis_tready = (count_q != 2'd2);
  assign cmd_valid_o   = (count_q != 2'd0);
  assign cmd_o         = mem_q[rd_ptr_q];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

>>> rtl/rfidwge_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfidwge_seq
// Back end: envelope sequencer, carries out one queued command per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module rfidwge_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rfidwge_pkg::cfg_t   cfg_i,
  input  logic                cmd_valid_i,
  input  rfidwge_pkg::cmd_t   cmd_i,
  output logic                cmd_pop_o,
  output logic                res_valid_o,
  output rfidwge_pkg::res_t   res_o,
  input  logic                res_ready_i
);
  import rfidwge_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_WAIT1,
    PH_SGAP,
    PH_OPCODE,
    PH_PASS,
    PH_LOCK,
    PH_DATA,
    PH_ADDR,
    PH_PROGRAM,
    PH_WAIT2,
    PH_RGAP,
    PH_RBITS
  } phase_e;

  phase_e            ph_q, ph_d;
  logic [5:0]        bp_q, bp_d;
  logic [TickW-1:0]  cnt_q, cnt_d;
  logic              gap_q, gap_d;
  logic [DataW-1:0]  hdata_q, hdata_d;
  logic [BlockW-1:0] hblock_q, hblock_d;
  logic              hpage_q, hpage_d;
  logic              hlock_q, hlock_d;
  logic              hpass_q, hpass_d;
  logic              step;
  logic [5:0]        bp_inc;
  logic [TickW-1:0]  cnt_dec;
  phase_e            nxt;
  res_t              res;

  // a zero duration counts as one tick
  function automatic logic [TickW-1:0] dur(input logic [TickW-1:0] v);
    return (v == '0) ? 10'd1 : v;
  endfunction

  function automatic logic is_bit(input phase_e p);
    logic r;
    unique case (p)
      PH_OPCODE, PH_PASS, PH_LOCK, PH_DATA, PH_ADDR, PH_RBITS: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] bit_count(input phase_e p);
    logic [5:0] r;
    unique case (p)
      PH_PASS, PH_DATA: r = 6'd32;
      PH_LOCK:          r = 6'd1;
      PH_ADDR:          r = 6'd3;
      default:          r = 6'd2;
    endcase
    return r;
  endfunction

  // bit value at a position of a field phase
  function automatic logic cur_bit(input phase_e p, input logic [5:0] pos,
                                   input logic [DataW-1:0] pwd,
                                   input logic [DataW-1:0] hdata,
                                   input logic [BlockW-1:0] hblock,
                                   input logic hpage, input logic hlock);
    logic [4:0] widx;
    logic [1:0] aidx;
    logic       r;
    widx = ~pos[4:0];
    aidx = 2'd2 - pos[1:0];
    unique case (p)
      PH_OPCODE: r = (pos == 6'd0) ? 1'b1 : hpage;
      PH_PASS:   r = pwd[widx];
      PH_LOCK:   r = hlock;
      PH_DATA:   r = hdata[widx];
      PH_ADDR:   r = (aidx == 2'd3) ? 1'b0 : hblock[aidx];
      default:   r = (pos == 6'd0);
    endcase
    return r;
  endfunction

  function automatic phase_e next_phase(input phase_e p, input logic wp);
    phase_e r;
    unique case (p)
      PH_WAIT1:   r = PH_SGAP;
      PH_SGAP:    r = PH_OPCODE;
      PH_OPCODE:  r = wp ? PH_PASS : PH_LOCK;
      PH_PASS:    r = PH_LOCK;
      PH_LOCK:    r = PH_DATA;
      PH_DATA:    r = PH_ADDR;
      PH_ADDR:    r = PH_PROGRAM;
      PH_PROGRAM: r = PH_WAIT2;
      PH_WAIT2:   r = PH_RGAP;
      PH_RGAP:    r = PH_RBITS;
      default:    r = PH_IDLE;
    endcase
    return r;
  endfunction

  function automatic logic level(input phase_e p, input logic gap);
    logic r;
    if (p == PH_SGAP || p == PH_RGAP) begin
      r = 1'b0;
    end else if (is_bit(p)) begin
      r = !gap;
    end else begin
      r = 1'b1;
    end
    return r;
  endfunction

  // step logic
  assign step        = cmd_valid_i && res_ready_i;
  assign cmd_pop_o   = step;
  assign res_valid_o = step;
  assign res_o       = res;
  assign bp_inc      = bp_q + 6'd1;
  assign cnt_dec     = cnt_q - 10'd1;
  assign nxt         = next_phase(ph_q, hpass_q);

  always_comb begin
    ph_d         = ph_q;
    bp_d         = bp_q;
    cnt_d        = cnt_q;
    gap_d        = gap_q;
    hdata_d      = hdata_q;
    hblock_d     = hblock_q;
    hpage_d      = hpage_q;
    hlock_d      = hlock_q;
    hpass_d      = hpass_q;
    res.done_res = 1'b0;
    res.rejected = 1'b0;
    unique case (cmd_i.kind)
      KIND_TICK: begin
        res.carrier_on = level(ph_q, gap_q);
        if (ph_q != PH_IDLE) begin
          cnt_d = cnt_dec;
          if (cnt_dec == '0) begin
            if (is_bit(ph_q) && !gap_q) begin
              // carrier part of a bit over, start its gap
              gap_d = 1'b1;
              cnt_d = dur(cfg_i.write_gap_ticks);
            end else if (is_bit(ph_q) && (bp_inc < bit_count(ph_q))) begin
              // next bit of the same field
              bp_d  = bp_inc;
              gap_d = 1'b0;
              cnt_d = cur_bit(ph_q, bp_inc, cfg_i.password, hdata_q, hblock_q,
                              hpage_q, hlock_q) ? dur(cfg_i.one_ticks)
                                                : dur(cfg_i.zero_ticks);
            end else begin
              // move on to the next phase
              ph_d  = nxt;
              bp_d  = 6'd0;
              gap_d = 1'b0;
              unique case (nxt)
                PH_WAIT1, PH_WAIT2: cnt_d = dur(cfg_i.wait_ticks);
                PH_SGAP, PH_RGAP:   cnt_d = dur(cfg_i.start_gap_ticks);
                PH_PROGRAM:         cnt_d = dur(cfg_i.program_ticks);
                PH_IDLE:            cnt_d = '0;
                default: cnt_d = cur_bit(nxt, 6'd0, cfg_i.password, hdata_q, hblock_q,
                                         hpage_q, hlock_q) ? dur(cfg_i.one_ticks)
                                                           : dur(cfg_i.zero_ticks);
              endcase
              res.done_res = (nxt == PH_IDLE);
            end
          end
        end
      end
      KIND_WRITE, KIND_RESET: begin
        if (ph_q != PH_IDLE) begin
          res.rejected = 1'b1;
        end else if (cmd_i.kind == KIND_WRITE) begin
          hdata_d  = cmd_i.data;
          hblock_d = cmd_i.block;
          hpage_d  = cmd_i.page;
          hlock_d  = cmd_i.lock_flag;
          hpass_d  = cmd_i.pass_mode;
          ph_d     = PH_WAIT1;
          bp_d     = 6'd0;
          gap_d    = 1'b0;
          cnt_d    = dur(cfg_i.wait_ticks);
        end else begin
          ph_d  = PH_RGAP;
          bp_d  = 6'd0;
          gap_d = 1'b0;
          cnt_d = dur(cfg_i.start_gap_ticks);
        end
        res.carrier_on = level(ph_d, gap_d);
      end
      default: begin
        res.carrier_on = level(ph_q, gap_q);
      end
    endcase
    res.busy_res = (ph_d != PH_IDLE);
  end

  // sequencer state and latched write command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q     <= PH_IDLE;
      bp_q     <= 6'd0;
      cnt_q    <= '0;
      gap_q    <= 1'b0;
      hdata_q  <= '0;
      hblock_q <= '0;
      hpage_q  <= 1'b0;
      hlock_q  <= 1'b0;
      hpass_q  <= 1'b0;
    end else if (step) begin
      ph_q     <= ph_d;
      bp_q     <= bp_d;
      cnt_q    <= cnt_d;
      gap_q    <= gap_d;
      hdata_q  <= hdata_d;
      hblock_q <= hblock_d;
      hpage_q  <= hpage_d;
      hlock_q  <= hlock_d;
      hpass_q  <= hpass_d;
    end
  end

  // gap flag only inside bit fields
  a_gap_in_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gap_q |-> is_bit(ph_q))
    else $error("gap flag set outside a bit field");

  // countdown is zero exactly when idle
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PH_IDLE) == (cnt_q == '0))
    else $error("countdown out of step with phase");

  // a finished sequence leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && res.done_res) |=> (ph_q == PH_IDLE))
    else $error("done reported but sequencer still busy");

  // a rejected command leaves the running sequence alone
  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && res.rejected) |-> (res.busy_res && ph_d == ph_q && cnt_d == cnt_q))
    else $error("rejected command disturbed the sequence");

endmodule

>>> rtl/rfidwge_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfidwge_outbuf
// Output side: two-entry result queue that drives the master stream.
// ----------------------------------------------------------------------------
module rfidwge_outbuf (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            res_valid_i,
  input  rfidwge_pkg::res_t               res_i,
  output logic                            res_ready_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [rfidwge_pkg::MDataW-1:0]  m_axis_tdata
);
  import rfidwge_pkg::*;

  res_t       mem_q [2];
  res_t       head;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  logic       pop;

  // queue control
  assign res_ready_o   = (count_q != 2'd2);
  assign m_axis_tvalid = (count_q != 2'd0);
  assign push          = res_valid_i && res_ready_o;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign head          = mem_q[rd_ptr_q];

  // pack result, carrier_on in bit 0
  assign m_axis_tdata = {4'b0000, head.rejected, head.done_res, head.busy_res,
                         head.carrier_on};

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

endmodule
